[hdl/vn_pkg.sv]
`default_nettype none
package vn_pkg;
    localparam int CompW = 32;
    localparam int MagW  = 32;
    localparam int SumW  = 64;
    localparam int LenW  = 32;
    localparam int QW    = 31;  // quotient magnitude bits, at most 2^30
    localparam int FracB = 30;

    typedef struct packed {
        logic signed [CompW-1:0] comp_x;
        logic signed [CompW-1:0] comp_y;
        logic signed [CompW-1:0] comp_z;
    } vn_in_t;

    typedef struct packed {
        logic signed [CompW-1:0] unit_x;
        logic signed [CompW-1:0] unit_y;
        logic signed [CompW-1:0] unit_z;
        logic        [LenW-1:0]  length;
        logic                    zero_vector;
    } vn_out_t;
endpackage
`default_nettype wire

[hdl/vn_pipe.sv]
`default_nettype none
// Stall-free-ahead pipeline: squares, 32-step root, 31-step divide per lane.
module vn_pipe
    import vn_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    adv,
    input  wire logic    in_v,
    input  vn_in_t       in_d,
    output logic         out_v,
    output vn_out_t      out_d
);
    localparam int SqS = 2;          // magnitude/square stage, sum stage
    localparam int RtS = LenW;       // one result bit per stage
    localparam int DvS = QW;         // one quotient bit per stage
    localparam int NS  = SqS + RtS + DvS;

    typedef struct packed {
        logic [2:0][MagW-1:0] mag;
        logic [2:0]           neg;
        logic [SumW-1:0]      rem;   // root remainder
        logic [LenW-1:0]      root;
        logic [2:0][QW:0]     drem;  // divide partial remainder (len < 2^32)
        logic [2:0][QW-1:0]   quo;
        logic [2:0][MagW+FracB-1:0] num;
    } st_t;

    logic [NS-1:0] v_reg;
    st_t  s_reg [NS];
    st_t  s_next [NS];
    logic [2:0][SumW-1:0] sq_reg;

    // stage 0: magnitudes and squares
    always_comb
    begin
        logic [2:0][CompW-1:0] c;
        c = {in_d.comp_x, in_d.comp_y, in_d.comp_z};
        s_next[0] = '0;
        for (int i = 0; i < 3; i++)
        begin
            s_next[0].neg[i] = c[2-i][CompW-1];
            s_next[0].mag[i] = c[2-i][CompW-1] ? (~c[2-i] + 1'b1) : c[2-i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= SumW'(s_next[0].mag[i]) * SumW'(s_next[0].mag[i]);
    end

    // stage 1: sum (fits: at most 3*2^62)
    always_comb
    begin
        s_next[1] = s_reg[0];
        s_next[1].rem  = sq_reg[0] + sq_reg[1] + sq_reg[2];
        s_next[1].root = '0;
    end

    // root stages: restoring, bit k from MSB
    for (genvar k = 0; k < RtS; k++)
    begin : g_rt
        localparam int B = RtS - 1 - k;
        always_comb
        begin
            logic [SumW+1:0] trial;
            s_next[SqS+k] = s_reg[SqS+k-1];
            trial = {2'b0, s_reg[SqS+k-1].rem}
                  - (({2'b0, 32'b0, s_reg[SqS+k-1].root} << (B + 1))
                     + ((SumW+2)'(1) << (2*B)));
            if (!trial[SumW+1])
            begin
                s_next[SqS+k].rem     = trial[SumW-1:0];
                s_next[SqS+k].root[B] = 1'b1;
            end
            if (k == RtS - 1)
                for (int i = 0; i < 3; i++)
                begin
                    s_next[SqS+k].num[i]  = {s_reg[SqS+k-1].mag[i], {FracB{1'b0}}};
                    s_next[SqS+k].drem[i] = {(QW+1){1'b0}};
                    s_next[SqS+k].quo[i]  = '0;
                end
        end
    end

    // divide stages: quotient bits QW-1..0 of num/root; higher bits are zero
    // since mag <= root, so the first partial remainder is the magnitude itself.
    for (genvar k = 0; k < DvS; k++)
    begin : g_dv
        localparam int B = DvS - 1 - k;
        always_comb
        begin
            logic [LenW:0] part;
            logic [LenW:0] diff;
            s_next[SqS+RtS+k] = s_reg[SqS+RtS+k-1];
            for (int i = 0; i < 3; i++)
            begin
                if (k == 0)
                    part = {1'b0, s_reg[SqS+RtS+k-1].num[i][MagW+FracB-1:FracB]};
                else
                    part = {s_reg[SqS+RtS+k-1].drem[i][LenW-1:0],
                            s_reg[SqS+RtS+k-1].num[i][B]};
                diff = part - {1'b0, s_reg[SqS+RtS+k-1].root};
                if (!diff[LenW])
                begin
                    s_next[SqS+RtS+k].drem[i] = diff[LenW-1:0];
                    s_next[SqS+RtS+k].quo[i][B] = 1'b1;
                end
                else
                    s_next[SqS+RtS+k].drem[i] = part[LenW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NS-2:0], in_v};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg[0] <= s_next[0];
            for (int j = 1; j < NS; j++)
                s_reg[j] <= s_next[j];
        end
    end

    always_comb
    begin
        st_t f;
        logic [2:0][CompW-1:0] u;
        f = s_reg[NS-1];
        for (int i = 0; i < 3; i++)
        begin
            if (f.root == '0)
                u[i] = '0;
            else if (f.neg[i])
                u[i] = ~{1'b0, f.quo[i]} + 1'b1;
            else
                u[i] = {1'b0, f.quo[i]};
        end
        out_v = v_reg[NS-1];
        out_d.unit_x = u[0];
        out_d.unit_y = u[1];
        out_d.unit_z = u[2];
        out_d.length = f.root;
        out_d.zero_vector = (f.root == '0);
    end
endmodule
`default_nettype wire

[hdl/vector3_normalize_core.sv]
`default_nettype none
// Channel | Signals                      | Item
// in      | in_valid, in_ready, in_data  | vn_in_t: comp_x, comp_y, comp_z
// out     | out_valid, out_ready, out_data | vn_out_t: unit_x..z, length, zero_vector
// One item per cycle while the pipeline advances. 66 register stages
// (square, sum, 32 root bits, 31 quotient bits, output register). The
// whole pipeline advances together; it holds only while the output
// register is full and not taken and the last stage holds an item.
// Reset clears valid bits only.
module vector3_normalize_core
    import vn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  vn_in_t    in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output vn_out_t   out_data
);
    logic    adv;
    logic    pv;
    vn_out_t pd;
    logic    ov_reg;
    vn_out_t od_reg;

    assign adv      = !ov_reg || out_ready || !pv;
    assign in_ready = adv;

    vn_pipe u_pipe (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .in_v  (in_valid),
        .in_d  (in_data),
        .out_v (pv),
        .out_d (pd)
    );

    // hold a bubble at the tail without stalling: load when empty or taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (!ov_reg || out_ready)
            ov_reg <= pv;
    end

    always_ff @(posedge clk)
    begin
        if ((!ov_reg || out_ready) && pv)
            od_reg <= pd;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
endmodule
`default_nettype wire
